// ===== sv/lcsu_pkg.sv =====
// shared types and constants for the life cell stencil update block
// no dependencies; used by lcsu_judge, lcsu_outq and the top level
package lcsu_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 11;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLS = 4'd1;

    // register widths and reset values
    localparam int GRID_ROWS_W = 11;
    localparam int GRID_COLS_W = 6;
    localparam logic [GRID_ROWS_W-1:0] GRID_ROWS_RESET = 11'd32;
    localparam logic [GRID_COLS_W-1:0] GRID_COLS_RESET = 6'd32;

    // stream widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 8;

    // rule B3/S23
    localparam int COUNT_W = 4;
    localparam logic [COUNT_W-1:0] BIRTH_COUNT = 4'd3;
    localparam logic [COUNT_W-1:0] KEEP_COUNT  = 4'd2;

    // one column of the window: [2] row above, [1] centre row, [0] row below
    typedef logic [2:0] t_column;
    // window: [0] left column, [1] centre column, [2] right column
    typedef t_column [2:0] t_window;

    typedef struct packed {
        logic               frame_last;
        logic [COUNT_W-1:0] neighbour_count;
        logic               next_alive;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_push;

    typedef enum logic {
        ST_RUN,
        ST_FLUSH
    } t_state;

endpackage

// ===== sv/lcsu_judge.sv =====
// neighbour count and next-state rule for the centre cell of a 3x3 window
// depends on lcsu_pkg
module lcsu_judge (
    input  lcsu_pkg::t_window i_window,
    input  logic              i_frame_last,
    output lcsu_pkg::t_result o_result
);
    import lcsu_pkg::*;

    logic [COUNT_W-1:0] count;

    // add up the eight neighbours
    always_comb begin
        count = '0;
        for (int x = 0; x < 3; x++) begin
            for (int y = 0; y < 3; y++) begin
                if (!(x == 1 && y == 1)) begin
                    count = count + COUNT_W'(i_window[x][y]);
                end
            end
        end
    end

    // birth or survival on three, hold on two, otherwise dead
    always_comb begin
        o_result.neighbour_count = count;
        o_result.frame_last      = i_frame_last;
        if (count == BIRTH_COUNT) begin
            o_result.next_alive = 1'b1;
        end else if (count == KEEP_COUNT) begin
            o_result.next_alive = i_window[1][1];
        end else begin
            o_result.next_alive = 1'b0;
        end
    end

endmodule

// ===== sv/lcsu_outq.sv =====
// two-entry result queue feeding the master stream side
// takes up to two results a cycle in order; depends on lcsu_pkg
module lcsu_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lcsu_pkg::t_push   i_push0,
    input  lcsu_pkg::t_push   i_push1,
    input  logic              i_tready,
    output logic              o_tvalid,
    output lcsu_pkg::t_result o_head,
    output logic [1:0]        o_free
);
    import lcsu_pkg::*;

    logic [1:0] r_count;
    logic [1:0] n_count;
    t_result    r_slot0;
    t_result    r_slot1;
    t_result    n_slot0;
    t_result    n_slot1;
    t_result    head_after;
    logic       pop;
    logic [1:0] cnt_after;

    assign o_tvalid = (r_count != 2'd0);
    assign o_head   = r_slot0;
    assign pop      = o_tvalid && i_tready;
    assign o_free   = 2'd2 - r_count + {1'b0, pop};

    // drop the head on pop, then append the new items behind what is left
    always_comb begin
        cnt_after  = r_count - {1'b0, pop};
        head_after = pop ? r_slot1 : r_slot0;
        n_slot0    = head_after;
        n_slot1    = r_slot1;
        unique case (cnt_after)
            2'd0: begin
                n_slot0 = i_push0.res;
                n_slot1 = i_push1.res;
            end
            2'd1: begin
                n_slot1 = i_push0.res;
            end
            default: begin
                n_slot1 = r_slot1;
            end
        endcase
        n_count = cnt_after + {1'b0, i_push0.valid} + {1'b0, i_push1.valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

endmodule

// ===== sv/life_cell_stencil_update_core.sv =====
// Game of Life (B3/S23) over a raster cell stream; throughput one cell per clock while the result
// queue has space, but the last cell of a frame stalls the input while the last row flushes.
// Latency: the result for cell (r, c) is queued at the edge taking cell (r+1, c+1), or the
// last cell of row r+1, and shows on the output at best the cycle after; last-row results
// are queued during the flush; the last of a full-width frame of 2+ rows waits for the next cell.
// Reset (synchronous, active low): positions zero, result queue empty, grid 32 x 32.
module life_cell_stencil_update_core #(
    parameter int MAX_COLS = 32,
    parameter int MAX_ROWS = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config write port
    input  logic                                i_cfg_we,
    input  logic [lcsu_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [lcsu_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // cell input stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [lcsu_pkg::S_TDATA_W-1:0]      i_s_tdata,   // [0] cell_alive
    // result stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [lcsu_pkg::M_TDATA_W-1:0]      o_m_tdata,   // [0] next_alive, [4:1] count
    output logic                                o_m_tlast    // frame_last
);
    import lcsu_pkg::*;

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = ($clog2(MAX_ROWS) < GRID_ROWS_W) ? $clog2(MAX_ROWS) : GRID_ROWS_W;
    localparam int PAD_W = M_TDATA_W - COUNT_W - 1;

    // config registers
    logic [GRID_ROWS_W-1:0] r_grid_rows;
    logic [GRID_COLS_W-1:0] r_grid_cols;
    logic                   cfg_restart;

    // control state
    t_state           r_state;
    t_state           n_state;
    logic [COL_W-1:0] r_col;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] r_row;
    logic [ROW_W-1:0] n_row;
    logic             r_held_valid;
    t_result          r_held;

    // line stores and window history
    logic [MAX_COLS-1:0] r_upper;
    logic [MAX_COLS-1:0] r_middle;
    t_column             r_win_l;
    t_column             r_win_m;

    logic [COL_W-1:0] last_col;
    logic [ROW_W-1:0] last_row;
    logic             is_run;
    logic             in_bit;
    logic             up_rd;
    logic             mid_rd;
    t_column          col_now;
    logic             judging;
    logic             at_first;
    logic             at_last;
    logic             a_valid;
    logic             b_valid;
    logic             hold_last;
    logic             divert_b;
    logic [1:0]       need;
    logic [1:0]       free;
    logic             step_ok;
    logic             step;
    t_window          win_a;
    t_window          win_b;
    t_result          res_a;
    t_result          res_b;
    t_push            c_held;
    t_push            c_a;
    t_push            c_b;
    t_push            push0;
    t_push            push1;
    t_result          head;

    // effective grid size, clamped to 1..MAX
    always_comb begin
        if (r_grid_cols == '0) begin
            last_col = '0;
        end else if (int'(r_grid_cols) > MAX_COLS) begin
            last_col = COL_W'(MAX_COLS - 1);
        end else begin
            last_col = COL_W'(r_grid_cols - 1'b1);
        end
        if (r_grid_rows == '0) begin
            last_row = '0;
        end else if (int'(r_grid_rows) > MAX_ROWS) begin
            last_row = ROW_W'(MAX_ROWS - 1);
        end else begin
            last_row = ROW_W'(r_grid_rows - 1'b1);
        end
    end

    assign cfg_restart = i_cfg_we &&
                         (i_cfg_index == REG_GRID_ROWS || i_cfg_index == REG_GRID_COLS);

    // new window column; row zero sees dead rows above, the flush sees a dead row below
    assign is_run = (r_state == ST_RUN);
    assign in_bit = i_s_tdata[0];
    assign up_rd  = r_upper[r_col];
    assign mid_rd = r_middle[r_col];

    always_comb begin
        if (!is_run) begin
            col_now = {up_rd, mid_rd, 1'b0};
        end else if (r_row == '0) begin
            col_now = {2'b00, in_bit};
        end else begin
            col_now = {up_rd, mid_rd, in_bit};
        end
    end

    // which results this column produces
    assign judging   = !is_run || (r_row != '0);
    assign at_first  = (r_col == '0);
    assign at_last   = (r_col == last_col);
    assign a_valid   = judging && !at_first;
    assign b_valid   = judging && at_last;
    // a full-width frame ends with one result more than a step can give; it waits
    assign hold_last = (last_col == COL_W'(MAX_COLS - 1)) && (last_row != '0);
    assign divert_b  = !is_run && b_valid && hold_last;

    // outputs of the sequencer: space check, ready and step
    always_comb begin
        need       = {1'b0, is_run && r_held_valid} + {1'b0, a_valid} + {1'b0, b_valid};
        step_ok    = (need <= free);
        o_s_tready = is_run && step_ok;
        step       = is_run ? (i_s_tvalid && o_s_tready) : step_ok;
    end

    // windows for the previous column and, at row end, the last column
    always_comb begin
        win_a[0] = (r_col == COL_W'(1)) ? 3'b000 : r_win_l;
        win_a[1] = r_win_m;
        win_a[2] = col_now;
        win_b[0] = at_first ? 3'b000 : r_win_m;
        win_b[1] = col_now;
        win_b[2] = 3'b000;
    end

    lcsu_judge u_judge_a (
        .i_window     (win_a),
        .i_frame_last (1'b0),
        .o_result     (res_a)
    );

    lcsu_judge u_judge_b (
        .i_window     (win_b),
        .i_frame_last (!is_run),
        .o_result     (res_b)
    );

    // push list in order: held result, previous column, last column
    always_comb begin
        c_held.valid = step && is_run && r_held_valid;
        c_held.res   = r_held;
        c_a.valid    = step && a_valid;
        c_a.res      = res_a;
        c_b.valid    = step && b_valid && !divert_b;
        c_b.res      = res_b;
        if (c_held.valid) begin
            push0 = c_held;
            push1 = c_a.valid ? c_a : c_b;
        end else if (c_a.valid) begin
            push0 = c_a;
            push1 = c_b;
        end else begin
            push0 = c_b;
            push1 = '0;
        end
    end

    lcsu_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push0  (push0),
        .i_push1  (push1),
        .i_tready (i_m_tready),
        .o_tvalid (o_m_tvalid),
        .o_head   (head),
        .o_free   (free)
    );

    assign o_m_tdata = {{PAD_W{1'b0}}, head.neighbour_count, head.next_alive};
    assign o_m_tlast = head.frame_last;

    // next position and state
    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        n_row   = r_row;
        if (cfg_restart) begin
            n_state = ST_RUN;
            n_col   = '0;
            n_row   = '0;
        end else if (step) begin
            if (at_last) begin
                n_col = '0;
                unique case (r_state)
                    ST_RUN: begin
                        if (r_row == last_row) begin
                            n_row   = '0;
                            n_state = ST_FLUSH;
                        end else begin
                            n_row = r_row + 1'b1;
                        end
                    end
                    ST_FLUSH: begin
                        n_state = ST_RUN;
                    end
                endcase
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows  <= GRID_ROWS_RESET;
            r_grid_cols  <= GRID_COLS_RESET;
            r_state      <= ST_RUN;
            r_col        <= '0;
            r_row        <= '0;
            r_held_valid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == REG_GRID_ROWS) begin
                r_grid_rows <= i_cfg_data[GRID_ROWS_W-1:0];
            end
            if (i_cfg_we && i_cfg_index == REG_GRID_COLS) begin
                r_grid_cols <= i_cfg_data[GRID_COLS_W-1:0];
            end
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            if (cfg_restart) begin
                r_held_valid <= 1'b0;
            end else if (step && divert_b) begin
                r_held_valid <= 1'b1;
            end else if (step && is_run) begin
                r_held_valid <= 1'b0;
            end
        end
    end

    // line stores shift down one row in place, window shifts one column
    always_ff @(posedge i_clk) begin
        if (step) begin
            if (is_run) begin
                r_upper[r_col]  <= (r_row == '0) ? 1'b0 : mid_rd;
                r_middle[r_col] <= in_bit;
            end
            r_win_l <= r_win_m;
            r_win_m <= col_now;
        end
        if (step && divert_b) begin
            r_held <= res_b;
        end
    end

    // a held result only waits for the first cell of the next frame
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_valid |-> (is_run && r_col == '0 && r_row == '0))
        else $error("held result outside frame start");

    // no cell is taken while the last row is flushed
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !is_run |-> !o_s_tready)
        else $error("input ready during flush");

    // positions stay inside the grid
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= last_col) && (r_row <= last_row))
        else $error("position beyond grid");

    // taking the last cell of a frame starts the flush at column zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_run && r_col == last_col && r_row == last_row && i_s_tvalid && o_s_tready
         && !cfg_restart) |=> (r_state == ST_FLUSH && r_col == '0))
        else $error("flush did not follow frame end");

endmodule
